### rtl/crt_pkg.sv
// Shared types, character codes and result codes for the CSV record tokenizer.
package crt_pkg;

    // Default saturation limit of the per-record field counter
    localparam int MAX_FIELDS_DEF = 256;

    // Request type of one input transfer
    localparam logic REQ_DATA = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Characters with meaning to the tokenizer
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        MODE_FIELD      = 3'd0,
        MODE_QUOTED     = 3'd1,
        MODE_QUOTE_SEEN = 3'd2,
        MODE_CR_SEEN    = 3'd3,
        MODE_DROP       = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        K_DATA       = 2'd0,
        K_FIELD_END  = 2'd1,
        K_RECORD_END = 2'd2,
        K_ERROR      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_AFTER_QUOTE = 3'd0,
        ERR_CR_NO_LF    = 3'd1,
        ERR_QUOTE_MID   = 3'd2,
        ERR_UNCLOSED    = 3'd3,
        ERR_COUNT       = 3'd4,
        ERR_EMPTY       = 3'd5
    } t_err;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        t_err        error_code;
        logic [8:0]  field_count;
    } t_result;

endpackage

### rtl/crt_parser.sv
// Parser state and per-byte next-state logic of the CSV record tokenizer.
module crt_parser
    import crt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int CW = $clog2(MAX_FIELDS + 1);

    t_mode         r_mode, n_mode;
    logic          r_has_data, n_has_data;
    logic          r_line, n_line;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_expected, n_expected;
    logic          r_header, n_header;

    logic [CW-1:0] count_inc;
    logic [CW+8:0] count_ext;
    logic [8:0]    count_out;
    logic          mismatch;
    logic          do_fld;
    logic          do_rec;
    logic          do_err;
    t_err          err_code;

    // Saturating count after closing the current field
    assign count_inc = (r_count < CW'(MAX_FIELDS)) ? r_count + CW'(1) : r_count;
    assign count_ext = {9'd0, count_inc};
    assign count_out = count_ext[8:0];
    assign mismatch  = r_header && (count_inc != r_expected);

    // Next state and result for the byte in transfer
    always_comb begin
        n_mode      = r_mode;
        n_has_data  = r_has_data;
        n_line      = r_line;
        n_count     = r_count;
        n_expected  = r_expected;
        n_header    = r_header;
        o_res_valid = 1'b0;
        o_res       = '0;
        do_fld      = 1'b0;
        do_rec      = 1'b0;
        do_err      = 1'b0;
        err_code    = ERR_AFTER_QUOTE;

        if (i_accept && i_req_type == REQ_END) begin
            // End of input: report what is open, then return to reset state
            n_mode     = MODE_FIELD;
            n_has_data = 1'b0;
            n_line     = 1'b0;
            n_count    = '0;
            n_expected = '0;
            n_header   = 1'b0;
            unique case (r_mode)
                MODE_DROP: begin
                end
                MODE_QUOTED: begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = K_ERROR;
                    o_res.error_code = ERR_UNCLOSED;
                end
                MODE_CR_SEEN: begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = K_ERROR;
                    o_res.error_code = ERR_CR_NO_LF;
                end
                MODE_FIELD, MODE_QUOTE_SEEN: begin
                    if (r_line) begin
                        o_res_valid = 1'b1;
                        if (mismatch) begin
                            o_res.kind       = K_ERROR;
                            o_res.error_code = ERR_COUNT;
                        end else begin
                            o_res.kind        = K_RECORD_END;
                            o_res.field_count = count_out;
                        end
                    end else if (!r_header) begin
                        o_res_valid      = 1'b1;
                        o_res.kind       = K_ERROR;
                        o_res.error_code = ERR_EMPTY;
                    end
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            unique case (r_mode)
                MODE_DROP: begin
                end
                MODE_CR_SEEN: begin
                    if (i_data_byte == CH_LF) begin
                        do_rec = 1'b1;
                    end else begin
                        do_err   = 1'b1;
                        err_code = ERR_CR_NO_LF;
                    end
                end
                MODE_QUOTED: begin
                    if (i_data_byte == CH_QUOTE) begin
                        n_mode = MODE_QUOTE_SEEN;
                    end else begin
                        o_res_valid    = 1'b1;
                        o_res.kind     = K_DATA;
                        o_res.out_byte = i_data_byte;
                    end
                end
                MODE_QUOTE_SEEN: begin
                    if (i_data_byte == CH_QUOTE) begin
                        // doubled quote stands for one quote
                        n_mode         = MODE_QUOTED;
                        o_res_valid    = 1'b1;
                        o_res.kind     = K_DATA;
                        o_res.out_byte = i_data_byte;
                    end else if (i_data_byte == CH_COMMA) begin
                        n_mode      = MODE_FIELD;
                        do_fld      = 1'b1;
                        o_res_valid = 1'b1;
                        o_res.kind  = K_FIELD_END;
                    end else if (i_data_byte == CH_LF) begin
                        do_rec = 1'b1;
                    end else if (i_data_byte == CH_CR) begin
                        n_mode = MODE_CR_SEEN;
                    end else begin
                        do_err   = 1'b1;
                        err_code = ERR_AFTER_QUOTE;
                    end
                end
                MODE_FIELD: begin
                    if (i_data_byte == CH_LF) begin
                        do_rec = 1'b1;
                    end else if (i_data_byte == CH_CR) begin
                        n_mode = MODE_CR_SEEN;
                    end else begin
                        n_line = 1'b1;
                        if (i_data_byte == CH_COMMA) begin
                            do_fld      = 1'b1;
                            o_res_valid = 1'b1;
                            o_res.kind  = K_FIELD_END;
                        end else if (i_data_byte == CH_QUOTE) begin
                            if (r_has_data) begin
                                do_err   = 1'b1;
                                err_code = ERR_QUOTE_MID;
                            end else begin
                                n_mode = MODE_QUOTED;
                            end
                        end else begin
                            n_has_data     = 1'b1;
                            o_res_valid    = 1'b1;
                            o_res.kind     = K_DATA;
                            o_res.out_byte = i_data_byte;
                        end
                    end
                end
                default: begin
                end
            endcase

            // Close a field on comma
            if (do_fld) begin
                n_count    = count_inc;
                n_has_data = 1'b0;
            end

            // Raise an error and drop input until end of input
            if (do_err) begin
                n_mode           = MODE_DROP;
                o_res_valid      = 1'b1;
                o_res.kind       = K_ERROR;
                o_res.error_code = err_code;
            end

            // Close a record on line end; skip empty lines
            if (do_rec) begin
                n_mode     = MODE_FIELD;
                n_has_data = 1'b0;
                n_line     = 1'b0;
                n_count    = '0;
                if (r_line) begin
                    o_res_valid = 1'b1;
                    if (mismatch) begin
                        n_mode           = MODE_DROP;
                        n_line           = r_line;
                        n_count          = count_inc;
                        o_res.kind       = K_ERROR;
                        o_res.error_code = ERR_COUNT;
                    end else begin
                        o_res.kind        = K_RECORD_END;
                        o_res.field_count = count_out;
                        if (!r_header) begin
                            n_header   = 1'b1;
                            n_expected = count_inc;
                        end
                    end
                end
            end
        end
    end

    // Hold parser state; advance on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FIELD;
            r_has_data <= 1'b0;
            r_line     <= 1'b0;
            r_count    <= '0;
            r_expected <= '0;
            r_header   <= 1'b0;
        end else begin
            r_mode     <= n_mode;
            r_has_data <= n_has_data;
            r_line     <= n_line;
            r_count    <= n_count;
            r_expected <= n_expected;
            r_header   <= n_header;
        end
    end

    // An error on a data byte leaves the parser dropping input
    a_err_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == K_ERROR && i_req_type == REQ_DATA) |=>
        (r_mode == MODE_DROP))
        else $error("error result did not enter drop mode");

    // End of input returns the parser to its reset state
    a_end_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req_type == REQ_END) |=>
        (r_mode == MODE_FIELD && !r_header && r_count == '0 && !r_line))
        else $error("end of input did not reset parser");

    // A reported record always holds at least one field
    a_rec_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == K_RECORD_END) |-> (count_inc != '0))
        else $error("record end with zero fields");

endmodule

### rtl/crt_out_skid.sv
// Output register with a skid stage for the tokenizer result channel.
module crt_out_skid
    import crt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_push_res,
    input  logic    i_out_stall,
    output logic    o_out_valid,
    output t_result o_out_res,
    output logic    o_full
);

    logic    r_out_vld;
    logic    r_skid_vld;
    t_result r_out_res;
    t_result r_skid_res;
    logic    take;

    assign take        = r_out_vld && !i_out_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_res   = r_out_res;
    assign o_full      = r_skid_vld;

    // Move results: skid drains first, new results fill the free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (take) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end
        end else if (i_push && (!r_out_vld || take)) begin
            r_out_vld <= 1'b1;
        end else if (i_push) begin
            r_skid_vld <= 1'b1;
        end else if (take) begin
            r_out_vld <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (take) begin
                r_out_res <= r_skid_res;
            end
        end else if (i_push && (!r_out_vld || take)) begin
            r_out_res <= i_push_res;
        end else if (i_push) begin
            r_skid_res <= i_push_res;
        end
    end

    // Skid holds a result only behind a waiting output
    a_skid_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid valid with empty output register");

    // No new result arrives while the skid stage is full
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !r_skid_vld)
        else $error("result pushed into full skid stage");

    // Output empties only after a transfer
    a_fall_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_out_vld) |-> $past(take))
        else $error("output valid dropped without transfer");

endmodule

### rtl/csv_record_tokenizer_top.sv
// A result is registered: it enters the output register, or the skid stage behind a held output.
// The input takes one byte per cycle while not stalled, also bytes that cause no result.
// The input stalls only while the output skid stage is full behind a stalled output.
// Reset is synchronous, active low: parser returns to field start, header and counts
// clear, and both output slots empty.
module csv_record_tokenizer_top
    import crt_pkg::*;
#(
    parameter int MAX_FIELDS = MAX_FIELDS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_req_type,
    input  logic [7:0] i_data_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_out_byte,
    output logic [2:0] o_error_code,
    output logic [8:0] o_field_count
);

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;
    logic    full;

    assign o_in_stall = full;
    assign accept     = i_in_valid && !full;

    crt_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_req_type  (i_req_type),
        .i_data_byte (i_data_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    crt_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_res  (res),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_res   (out_res),
        .o_full      (full)
    );

    assign o_kind        = out_res.kind;
    assign o_out_byte    = out_res.out_byte;
    assign o_error_code  = out_res.error_code;
    assign o_field_count = out_res.field_count;

endmodule

### dv/tb_top.sv
// Self-checking testbench for csv_record_tokenizer_top with a scoreboard class.
module tb_top
    import crt_pkg::*;
;

    localparam int LIMIT_CYCLES = 400000;
    localparam int ITEM_TARGET  = 1400;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;

    // Predict tokens from the accepted bytes and match them against the output
    class csv_scoreboard;
        t_result token_q[$];
        int      errors;
        int      live_items;
        t_mode   mode;
        bit      field_has_data;
        bit      line_has_chars;
        int      fields_in_record;
        int      record_fields;
        bit      header_seen;

        function new();
            errors     = 0;
            live_items = 0;
            restart();
        endfunction

        function void begin_line();
            mode             = MODE_FIELD;
            field_has_data   = 1'b0;
            line_has_chars   = 1'b0;
            fields_in_record = 0;
        endfunction

        function void restart();
            begin_line();
            record_fields = 0;
            header_seen   = 1'b0;
        endfunction

        function t_result make(t_kind k, logic [7:0] b, t_err e, logic [8:0] n);
            t_result r;
            r.kind        = k;
            r.out_byte    = b;
            r.error_code  = e;
            r.field_count = n;
            return r;
        endfunction

        function t_result flag_error(t_err e);
            mode = MODE_DROP;
            return make(K_ERROR, 8'h00, e, 9'd0);
        endfunction

        function void close_field();
            if (fields_in_record < MAX_FIELDS_DEF)
                fields_in_record++;
            field_has_data = 1'b0;
        endfunction

        // Close the current line; blank lines give no token
        function bit close_record(output t_result r);
            int n;
            r = make(K_DATA, 8'h00, ERR_AFTER_QUOTE, 9'd0);
            if (!line_has_chars) begin
                begin_line();
                return 1'b0;
            end
            close_field();
            n = fields_in_record;
            if (header_seen && n != record_fields) begin
                r = flag_error(ERR_COUNT);
                return 1'b1;
            end
            if (!header_seen) begin
                header_seen   = 1'b1;
                record_fields = n;
            end
            begin_line();
            r = make(K_RECORD_END, 8'h00, ERR_AFTER_QUOTE, n[8:0]);
            return 1'b1;
        endfunction

        // End of input always returns the parser to its reset state
        function bit finish_input(output t_result r);
            bit got;
            got = 1'b0;
            r   = make(K_DATA, 8'h00, ERR_AFTER_QUOTE, 9'd0);
            case (mode)
                MODE_DROP: ;
                MODE_QUOTED: begin
                    r   = flag_error(ERR_UNCLOSED);
                    got = 1'b1;
                end
                MODE_CR_SEEN: begin
                    r   = flag_error(ERR_CR_NO_LF);
                    got = 1'b1;
                end
                default: begin
                    got = close_record(r);
                    if (!got && !header_seen) begin
                        r   = flag_error(ERR_EMPTY);
                        got = 1'b1;
                    end
                end
            endcase
            restart();
            return got;
        endfunction

        function bit predict_token(logic req, logic [7:0] c, output t_result r);
            r = make(K_DATA, 8'h00, ERR_AFTER_QUOTE, 9'd0);
            if (req == REQ_END)
                return finish_input(r);
            case (mode)
                MODE_DROP: return 1'b0;
                MODE_CR_SEEN: begin
                    if (c == CH_LF)
                        return close_record(r);
                    r = flag_error(ERR_CR_NO_LF);
                    return 1'b1;
                end
                MODE_QUOTED: begin
                    if (c == CH_QUOTE) begin
                        mode = MODE_QUOTE_SEEN;
                        return 1'b0;
                    end
                    r = make(K_DATA, c, ERR_AFTER_QUOTE, 9'd0);
                    return 1'b1;
                end
                MODE_QUOTE_SEEN: begin
                    if (c == CH_QUOTE) begin
                        mode = MODE_QUOTED;
                        r    = make(K_DATA, c, ERR_AFTER_QUOTE, 9'd0);
                        return 1'b1;
                    end
                    if (c == CH_COMMA) begin
                        mode = MODE_FIELD;
                        close_field();
                        r = make(K_FIELD_END, 8'h00, ERR_AFTER_QUOTE, 9'd0);
                        return 1'b1;
                    end
                    if (c == CH_LF)
                        return close_record(r);
                    if (c == CH_CR) begin
                        mode = MODE_CR_SEEN;
                        return 1'b0;
                    end
                    r = flag_error(ERR_AFTER_QUOTE);
                    return 1'b1;
                end
                default: ;
            endcase
            // unquoted field
            if (c == CH_LF)
                return close_record(r);
            if (c == CH_CR) begin
                mode = MODE_CR_SEEN;
                return 1'b0;
            end
            line_has_chars = 1'b1;
            if (c == CH_COMMA) begin
                close_field();
                r = make(K_FIELD_END, 8'h00, ERR_AFTER_QUOTE, 9'd0);
                return 1'b1;
            end
            if (c == CH_QUOTE) begin
                if (field_has_data) begin
                    r = flag_error(ERR_QUOTE_MID);
                    return 1'b1;
                end
                mode = MODE_QUOTED;
                return 1'b0;
            end
            field_has_data = 1'b1;
            r = make(K_DATA, c, ERR_AFTER_QUOTE, 9'd0);
            return 1'b1;
        endfunction

        // Note one accepted input transfer
        function void note_input(logic req, logic [7:0] c);
            t_result r;
            if (req == REQ_END || mode != MODE_DROP)
                live_items++;
            if (predict_token(req, c, r))
                token_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [8:0] want, logic [8:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %0d, actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Check one accepted output transfer against the oldest prediction
        function void check_result(logic [1:0] k, logic [7:0] b, logic [2:0] e,
                                   logic [8:0] n);
            t_result want;
            if (token_q.size() == 0) begin
                $display({"%0t: unexpected token: expected none, ",
                          "actual kind %0d byte %0d code %0d count %0d"},
                         $time, k, b, e, n);
                errors++;
                return;
            end
            want = token_q.pop_front();
            compare_field("kind", 9'(want.kind), 9'(k));
            compare_field("out_byte", 9'(want.out_byte), 9'(b));
            compare_field("error_code", 9'(want.error_code), 9'(e));
            compare_field("field_count", want.field_count, n);
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic       i_req_type    = REQ_DATA;
    logic [7:0] i_data_byte   = 8'h00;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_out_byte;
    logic [2:0] o_error_code;
    logic [8:0] o_field_count;

    csv_scoreboard sb = new();
    int  in_gap_max  = 15;
    int  out_gap_max = 15;
    bit  out_hold_req = 1'b0;

    csv_record_tokenizer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_data_byte   (i_data_byte),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_error_code  (o_error_code),
        .o_field_count (o_field_count)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // Observe transfers on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_input(i_req_type, i_data_byte);
            if (o_out_valid && !i_out_stall)
                sb.check_result(o_kind, o_out_byte, o_error_code, o_field_count);
        end
    end

    function automatic int draw_gap(int max_gap);
        if (max_gap == 0 || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, max_gap);
    endfunction

    // Drain tokens with random stalls and one long hold-off on request
    initial begin
        int wait_n;
        wait (i_rst_n);
        forever begin
            if (out_hold_req) begin
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                out_hold_req = 1'b0;
            end else begin
                wait_n = draw_gap(out_gap_max);
                if (wait_n > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (wait_n) @(posedge i_clk);
                end
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one input transfer and hold it until accepted
    task automatic put(logic req, logic [7:0] b);
        int gap;
        gap = out_hold_req ? 0 : draw_gap(in_gap_max);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put(REQ_DATA, s[i]);
    endtask

    task automatic put_end();
        put(REQ_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic put_eol();
        if ($urandom_range(0, 1) == 1)
            put(REQ_DATA, CH_CR);
        put(REQ_DATA, CH_LF);
    endtask

    // Pick a byte weighted toward the characters that steer the parser
    function automatic logic [7:0] noise_byte();
        case ($urandom_range(0, 5))
            0: return CH_COMMA;
            1: return CH_QUOTE;
            2: return CH_CR;
            3: return CH_LF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic put_field();
        logic [7:0] b;
        int len;
        case ($urandom_range(0, 3))
            0: ;
            1, 2: begin
                len = $urandom_range(1, 6);
                repeat (len) begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_COMMA || b == CH_QUOTE || b == CH_CR || b == CH_LF);
                    put(REQ_DATA, b);
                end
            end
            default: begin
                // quoted: any byte, a quote doubled
                len = $urandom_range(0, 6);
                put(REQ_DATA, CH_QUOTE);
                repeat (len) begin
                    b = ($urandom_range(0, 4) == 0) ? noise_byte()
                                                    : 8'($urandom_range(0, 255));
                    put(REQ_DATA, b);
                    if (b == CH_QUOTE)
                        put(REQ_DATA, CH_QUOTE);
                end
                put(REQ_DATA, CH_QUOTE);
            end
        endcase
    endtask

    // Send a well-formed document with rare flaws, then end of input
    task automatic put_document();
        int cols, rows, n;
        cols = $urandom_range(1, 5);
        rows = $urandom_range(1, 6);
        for (int r = 0; r < rows; r++) begin
            if ($urandom_range(0, 7) == 0)
                put_eol();
            n = ($urandom_range(0, 11) == 0) ? $urandom_range(1, 6) : cols;
            for (int f = 0; f < n; f++) begin
                if (f > 0)
                    put(REQ_DATA, CH_COMMA);
                if ($urandom_range(0, 39) == 0)
                    put(REQ_DATA, noise_byte());
                put_field();
            end
            if (r < rows - 1 || $urandom_range(0, 1) == 1)
                put_eol();
        end
        put_end();
    endtask

    task automatic put_noise_doc();
        repeat ($urandom_range(1, 20))
            put(REQ_DATA, noise_byte());
        put_end();
    endtask

    // Main stimulus
    initial begin
        bit pressure_done;
        pressure_done = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty input, blank line only
        put_end();
        put_text("\n");
        put_end();
        // doubled quote, extreme data bytes, CRLF record
        put_text("\"\"\"\",");
        put(REQ_DATA, 8'h00);
        put(REQ_DATA, 8'hFF);
        put_text("\r\n");
        // quote inside unquoted field, then dropped byte
        put_text("a\"x");
        put_end();
        // junk after closing quote
        put_text("\"\"y");
        put_end();
        // unclosed quote at end of input
        put_text("\"");
        put_end();
        // CR followed by data, CR followed by end of input
        put_text("\ra");
        put_end();
        put_text("\r");
        put_end();
        // closing quote then end of input closes the record
        put_text("\"\"");
        put_end();
        // unterminated record with the wrong count
        put_text("a\n,");
        put_end();

        // saturate the field counter in header and body
        repeat (257) put(REQ_DATA, CH_COMMA);
        put(REQ_DATA, CH_LF);
        put(REQ_DATA, 8'h78);
        repeat (255) put(REQ_DATA, CH_COMMA);
        put_end();

        // random documents with changing idle patterns
        while (sb.live_items < ITEM_TARGET) begin
            in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 15;
            out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
            if (!pressure_done && sb.live_items > ITEM_TARGET / 2) begin
                out_hold_req  = 1'b1;
                pressure_done = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
                put_noise_doc();
            else
                put_document();
        end
        i_in_valid <= 1'b0;

        // drain, then allow stray tokens to show up
        while (sb.token_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
rtl/crt_pkg.sv
rtl/crt_parser.sv
rtl/crt_out_skid.sv
rtl/csv_record_tokenizer_top.sv
dv/tb_top.sv
